@@ design/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probing hash table modules.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int TABLE_SLOTS = 256;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int HALF_SLOTS  = TABLE_SLOTS / 2;

	localparam logic MODE_SET    = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	localparam logic [1:0] RSP_DONE     = 2'd0;
	localparam logic [1:0] RSP_FULL     = 2'd1;
	localparam logic [1:0] RSP_ZERO_KEY = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [63:0] hash_code;
		logic [63:0] key_word;
		logic [63:0] new_value;
	} lpht_req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] read_value;
		logic [7:0]  slot_index;
		logic [1:0]  status;
	} lpht_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       advance;
		logic       finish;
		logic       reject;
		logic [1:0] rej_status;
	} lpht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic key_zero;
		logic refuse;
		logic is_hit;
		logic is_empty;
		logic last_probe;
	} lpht_stat_t;

endpackage

@@ design/lpht_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpht_ctrl
// Request sequencer: screens a transaction, then walks the probe one slot a
// cycle until the datapath reports a hit, an empty slot or a full sweep.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lpht_pkg::lpht_stat_t stat,
	output lpht_pkg::lpht_cmd_t  cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PROBE = 1'b1;

	logic state_q;
	logic state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (stat.key_zero) begin
						cmd.reject     = 1'b1;
						cmd.rej_status = lpht_pkg::RSP_ZERO_KEY;
					end else if (stat.refuse) begin
						cmd.reject     = 1'b1;
						cmd.rej_status = lpht_pkg::RSP_FULL;
					end else begin
						cmd.load = 1'b1;
						state_d  = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (stat.is_hit || stat.is_empty || stat.last_probe) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.advance, cmd.finish, cmd.reject}))
		else $error("lpht_ctrl: more than one command in a cycle");

endmodule

@@ design/lpht_dp.sv @@
// ----------------------------------------------------------------------------
// lpht_dp
// Slot memories, probe index, entry count and result register.
// ----------------------------------------------------------------------------
module lpht_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lpht_pkg::lpht_req_t  req,
	input  lpht_pkg::lpht_cmd_t  cmd,
	output lpht_pkg::lpht_stat_t stat,
	output logic                done,
	output lpht_pkg::lpht_rsp_t  rsp
);

	logic [63:0] key_mem   [lpht_pkg::TABLE_SLOTS];
	logic [63:0] hash_mem  [lpht_pkg::TABLE_SLOTS];
	logic [63:0] value_mem [lpht_pkg::TABLE_SLOTS];

	logic [lpht_pkg::TABLE_SLOTS-1:0] valid_q;
	logic [lpht_pkg::CNT_W-1:0]       entry_count_q;
	lpht_pkg::lpht_req_t              req_q;
	logic [lpht_pkg::SLOT_W-1:0]      idx_q;
	logic [lpht_pkg::SLOT_W-1:0]      start_q;
	logic [lpht_pkg::SLOT_W-1:0]      probe_cnt_q;
	logic [lpht_pkg::SLOT_W-1:0]      rd_addr;

	logic        valid_rd_s1;
	logic [63:0] key_rd_s1;
	logic [63:0] hash_rd_s1;
	logic [63:0] value_rd_s1;

	logic      done_q;
	lpht_pkg::lpht_rsp_t rsp_q;
	lpht_pkg::lpht_rsp_t fin_rsp;

	logic wr_insert;
	logic wr_update;
	logic wr_delete;

	// read one slot ahead so the compare runs every cycle
	always_comb begin
		if (cmd.load) begin
			rd_addr = req.hash_code[lpht_pkg::SLOT_W-1:0];
		end else if (cmd.advance) begin
			rd_addr = idx_q + 1'b1;
		end else begin
			rd_addr = idx_q;
		end
	end

	assign stat.key_zero   = (req.key_word == 64'd0);
	assign stat.refuse     = (req.mode == lpht_pkg::MODE_SET) &&
		(entry_count_q >= lpht_pkg::CNT_W'(lpht_pkg::HALF_SLOTS));
	assign stat.is_empty   = !valid_rd_s1;
	assign stat.is_hit     = valid_rd_s1 && (hash_rd_s1 == req_q.hash_code) &&
		(key_rd_s1 == req_q.key_word);
	assign stat.last_probe = (probe_cnt_q == '1);

	assign wr_insert = cmd.finish && (req_q.mode == lpht_pkg::MODE_SET) &&
		stat.is_empty;
	assign wr_update = cmd.finish && (req_q.mode == lpht_pkg::MODE_SET) &&
		stat.is_hit && (req_q.new_value != 64'd0);
	assign wr_delete = cmd.finish && (req_q.mode == lpht_pkg::MODE_SET) &&
		stat.is_hit && (req_q.new_value == 64'd0);

	always_comb begin
		fin_rsp            = '0;
		fin_rsp.status     = lpht_pkg::RSP_DONE;
		fin_rsp.slot_index = 8'(idx_q);
		if (stat.is_hit) begin
			fin_rsp.found = 1'b1;
			if (req_q.mode == lpht_pkg::MODE_LOOKUP) begin
				fin_rsp.read_value = value_rd_s1;
			end
		end else if (!stat.is_empty) begin
			// full sweep without a hit or a hole
			if (req_q.mode == lpht_pkg::MODE_LOOKUP) begin
				fin_rsp.slot_index = 8'(start_q);
			end else begin
				fin_rsp.slot_index = '0;
				fin_rsp.status     = lpht_pkg::RSP_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_insert) begin
			key_mem[idx_q] <= req_q.key_word;
		end
		key_rd_s1 <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_insert) begin
			hash_mem[idx_q] <= req_q.hash_code;
		end
		hash_rd_s1 <= hash_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_insert || wr_update) begin
			value_mem[idx_q] <= req_q.new_value;
		end
		value_rd_s1 <= value_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			entry_count_q <= '0;
			valid_rd_s1   <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			valid_rd_s1 <= valid_q[rd_addr];
			done_q      <= cmd.finish || cmd.reject;
			if (wr_insert) begin
				valid_q[idx_q] <= 1'b1;
				entry_count_q  <= entry_count_q + 1'b1;
			end else if (wr_delete) begin
				valid_q[idx_q] <= 1'b0;
				if (entry_count_q != '0) begin
					entry_count_q <= entry_count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= req;
			idx_q       <= req.hash_code[lpht_pkg::SLOT_W-1:0];
			start_q     <= req.hash_code[lpht_pkg::SLOT_W-1:0];
			probe_cnt_q <= '0;
		end else if (cmd.advance) begin
			idx_q       <= idx_q + 1'b1;
			probe_cnt_q <= probe_cnt_q + 1'b1;
		end
		if (cmd.reject) begin
			rsp_q <= '{found: 1'b0, read_value: 64'd0, slot_index: 8'd0,
				status: cmd.rej_status};
		end else if (cmd.finish) begin
			rsp_q <= fin_rsp;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(entry_count_q))
		else $error("lpht_dp: entry count differs from occupied slots");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= lpht_pkg::CNT_W'(lpht_pkg::HALF_SLOTS))
		else $error("lpht_dp: entry count above half load");

	a_hit_reports_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && stat.is_hit) |=> (done_q && rsp_q.found &&
		rsp_q.status == lpht_pkg::RSP_DONE))
		else $error("lpht_dp: hit not reported as found");

endmodule

@@ design/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing table of 64-bit keys with linear probing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; req carries mode,
// hash_code, key_word and new_value. Every request gives exactly one result:
// done is high for one cycle with rsp (found, read_value, slot_index, status)
// and the receiver must take it then, it cannot hold results off.
// A zero key, or a set while half the slots are occupied, is answered without
// probing: done follows in the cycle after the accept and busy never rises.
// Otherwise the probe reads one slot per cycle through the registered read
// port of the slot memories, starting at the hash's low bits and wrapping.
// A probe keeps busy high while it walks the slots and raises done in the
// cycle after the last one; the next request may start in that same cycle.
// Reset clears all occupancy bits and the entry count at once, so the table
// is empty and ready in the first cycle after arst_n rises.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lpht_pkg::lpht_req_t  req,
	output logic                done,
	output lpht_pkg::lpht_rsp_t  rsp
);

	lpht_pkg::lpht_cmd_t  cmd;
	lpht_pkg::lpht_stat_t stat;

	lpht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	lpht_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
